[sv/okv_pkg.sv]
// ----------------------------------------------------------------------------
// okv_pkg - shared types and constants for the object key validator
// Byte codes for the UTF-8 decoder and the path segment tracker, state
// structs passed between the step modules, and the status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package okv_pkg;

    // Field and state widths
    localparam int unsigned KEY_LEN_W = 12;
    localparam int unsigned COUNT_W   = 13;
    localparam int unsigned DEPTH_W   = 12;
    localparam int unsigned STATUS_W  = 2;

    localparam logic [KEY_LEN_W-1:0] MAX_KEY_LEN_RESET = 12'd1024;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd2;

    // UTF-8 lead byte ranges
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD3_SURR = 8'hED;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD4_MAX  = 8'hF4;

    // Continuation byte form and second byte bounds
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] CONT_A0   = 8'hA0;
    localparam logic [7:0] CONT_90   = 8'h90;
    localparam logic [7:0] CONT_8F   = 8'h8F;

    // Path characters
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    // Range rule for the next continuation byte
    typedef enum logic [2:0] {
        RULE_NONE  = 3'd0,
        RULE_GE_A0 = 3'd1,
        RULE_LT_A0 = 3'd2,
        RULE_GE_90 = 3'd3,
        RULE_LE_8F = 3'd4
    } rule_t;

    // Class of the open path segment
    typedef enum logic [1:0] {
        SEG_EMPTY  = 2'd0,
        SEG_DOT    = 2'd1,
        SEG_DOTDOT = 2'd2,
        SEG_OTHER  = 2'd3
    } seg_class_t;

    typedef struct packed {
        logic [1:0] cont_left;
        rule_t      rule;
    } utf8_state_t;

    typedef struct packed {
        seg_class_t         seg;
        logic [DEPTH_W-1:0] depth;
    } path_state_t;

endpackage : okv_pkg

`default_nettype wire

[sv/okv_utf8_step.sv]
// ----------------------------------------------------------------------------
// okv_utf8_step - one byte of UTF-8 decoding
// Combinational next state of the decoder: expected continuation count and
// the range rule on the second byte, plus an error flag for this byte.
// ----------------------------------------------------------------------------
`default_nettype none

module okv_utf8_step (
    input  wire logic                 byte_en,
    input  wire logic [7:0]           data_byte,
    input  wire okv_pkg::utf8_state_t state_cur,
    output okv_pkg::utf8_state_t      state_next,
    output logic                      byte_err
);
    import okv_pkg::*;

    always_comb begin
        state_next = state_cur;
        byte_err   = 1'b0;
        if (byte_en) begin
            if (state_cur.cont_left == 2'd0) begin
                // expecting a lead byte
                state_next.rule = RULE_NONE;
                if (data_byte <= ASCII_MAX) begin
                    state_next.cont_left = 2'd0;
                end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
                    state_next.cont_left = 2'd1;
                end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
                    state_next.cont_left = 2'd2;
                    if (data_byte == LEAD3_MIN) begin
                        state_next.rule = RULE_GE_A0;
                    end else if (data_byte == LEAD3_SURR) begin
                        state_next.rule = RULE_LT_A0;
                    end
                end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
                    state_next.cont_left = 2'd3;
                    if (data_byte == LEAD4_MIN) begin
                        state_next.rule = RULE_GE_90;
                    end else if (data_byte == LEAD4_MAX) begin
                        state_next.rule = RULE_LE_8F;
                    end
                end else begin
                    byte_err = 1'b1;
                end
            end else begin
                // continuation byte: form, then the pending range rule
                if ((data_byte & CONT_MASK) != CONT_TAG) begin
                    byte_err = 1'b1;
                end
                unique case (state_cur.rule)
                    RULE_GE_A0: if (data_byte < CONT_A0) byte_err = 1'b1;
                    RULE_LT_A0: if (data_byte >= CONT_A0) byte_err = 1'b1;
                    RULE_GE_90: if (data_byte < CONT_90) byte_err = 1'b1;
                    RULE_LE_8F: if (data_byte > CONT_8F) byte_err = 1'b1;
                    default: ;
                endcase
                state_next.rule      = RULE_NONE;
                state_next.cont_left = state_cur.cont_left - 2'd1;
            end
        end
    end

endmodule : okv_utf8_step

`default_nettype wire

[sv/okv_path_step.sv]
// ----------------------------------------------------------------------------
// okv_path_step - path segment classification and depth tracking
// Combinational next segment class and depth for one item. A slash or the
// end of the key closes the open segment; at most one close per item.
// ----------------------------------------------------------------------------
`default_nettype none

module okv_path_step (
    input  wire logic                 byte_en,
    input  wire logic                 key_end,
    input  wire logic [7:0]           data_byte,
    input  wire okv_pkg::path_state_t state_cur,
    output okv_pkg::path_state_t      state_next,
    output logic                      depth_err
);
    import okv_pkg::*;

    seg_class_t cls_after;
    seg_class_t close_cls;
    logic       slash_close;

    // Segment class after this byte
    always_comb begin
        cls_after   = state_cur.seg;
        slash_close = 1'b0;
        if (byte_en) begin
            if (data_byte == CHAR_SLASH) begin
                slash_close = 1'b1;
                cls_after   = SEG_EMPTY;
            end else if (data_byte == CHAR_DOT) begin
                case (state_cur.seg)
                    SEG_EMPTY: cls_after = SEG_DOT;
                    SEG_DOT:   cls_after = SEG_DOTDOT;
                    default:   cls_after = SEG_OTHER;
                endcase
            end else begin
                cls_after = SEG_OTHER;
            end
        end
    end

    // A slash closes the old segment; the end of key closes the new one.
    // After a slash the new segment is empty, so one close covers both.
    always_comb begin
        if (slash_close) begin
            close_cls = state_cur.seg;
        end else if (key_end) begin
            close_cls = cls_after;
        end else begin
            close_cls = SEG_EMPTY;
        end
    end

    // Depth update on the closed segment
    always_comb begin
        state_next.seg   = cls_after;
        state_next.depth = state_cur.depth;
        depth_err        = 1'b0;
        case (close_cls)
            SEG_DOTDOT: begin
                if (state_cur.depth == '0) begin
                    depth_err = 1'b1;
                end else begin
                    state_next.depth = state_cur.depth - 1'b1;
                end
            end
            SEG_OTHER: begin
                if (state_cur.depth != '1) begin
                    state_next.depth = state_cur.depth + 1'b1;
                end
            end
            default: ;
        endcase
        if (key_end) begin
            state_next.seg = SEG_EMPTY;
        end
    end

endmodule : okv_path_step

`default_nettype wire

[sv/object_key_validator.sv]
// ----------------------------------------------------------------------------
// object_key_validator - streaming object key checker
// Takes a key one byte per item on the s_ channel (s_has_byte low marks an
// end-only item) and, on the item with s_last set, returns one status item
// on the m_ channel: ok, too long (wins over all else) or invalid (bad
// UTF-8 or a ".." climbing above the root).
// The limit is to be written on the cfg_ channel (always ready) only while idle;
// the block itself does not enforce this. Reset sets it to 1024 bytes.
// An item taken sits in the input register; when it moves on it is folded
// into the running key state and, if last, its status shows on m_valid.
// Throughput: one item per cycle while no last item waits behind an untaken
// result, set by the single step of byte logic between the input register
// and the state and result registers.
// A stalled result holds the result register; the input register still
// drains items without s_last, and s_ready drops only when a last item
// waits behind an untaken result.
// Reset (aresetn low, synchronous) clears both registers' valid flags and
// all per-key state.
// ----------------------------------------------------------------------------
`default_nettype none

module object_key_validator (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [okv_pkg::KEY_LEN_W-1:0]      cfg_max_key_length,
    // key bytes in
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [7:0]                         s_data_byte,
    input  wire logic                               s_has_byte,
    input  wire logic                               s_last,
    // status out
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [okv_pkg::STATUS_W-1:0]            m_status
);
    import okv_pkg::*;

    // Registers
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_has_reg;
    logic                  in_last_reg;
    logic [KEY_LEN_W-1:0]  max_len_reg;
    utf8_state_t           utf_reg;
    path_state_t           path_reg;
    logic [COUNT_W-1:0]    byte_count_reg;
    logic                  key_invalid_reg;
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;

    // Step logic
    utf8_state_t           utf_next;
    path_state_t           path_next;
    logic                  utf_err;
    logic                  depth_err;
    logic [COUNT_W-1:0]    count_upd;
    logic                  invalid_upd;
    logic [STATUS_W-1:0]   status_next;
    logic                  out_free;
    logic                  consume;

    // Handshake: the input item moves on unless it is last and the result
    // register is still held
    assign out_free  = !m_valid_reg || m_ready;
    assign consume   = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready   = !in_valid_reg || consume;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;

    okv_utf8_step u_utf8 (
        .byte_en    (in_has_reg),
        .data_byte  (in_byte_reg),
        .state_cur  (utf_reg),
        .state_next (utf_next),
        .byte_err   (utf_err)
    );

    okv_path_step u_path (
        .byte_en    (in_has_reg),
        .key_end    (in_last_reg),
        .data_byte  (in_byte_reg),
        .state_cur  (path_reg),
        .state_next (path_next),
        .depth_err  (depth_err)
    );

    // Running count, sticky error and the status of a closing key
    always_comb begin
        count_upd = byte_count_reg;
        if (in_has_reg && byte_count_reg != '1) begin
            count_upd = byte_count_reg + 1'b1;
        end
        invalid_upd = key_invalid_reg | utf_err | depth_err;
        if (count_upd > {1'b0, max_len_reg}) begin
            status_next = STATUS_TOO_LONG;
        end else if (invalid_upd || utf_next.cont_left != 2'd0) begin
            status_next = STATUS_INVALID;
        end else begin
            status_next = STATUS_OK;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_has_reg  <= s_has_byte;
            in_last_reg <= s_last;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_KEY_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_max_key_length;
        end
    end

    // Per-key state: updated per item, cleared at the end of a key
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utf_reg         <= '{cont_left: 2'd0, rule: RULE_NONE};
            path_reg        <= '{seg: SEG_EMPTY, depth: '0};
            byte_count_reg  <= '0;
            key_invalid_reg <= 1'b0;
        end else if (consume) begin
            if (in_last_reg) begin
                utf_reg         <= '{cont_left: 2'd0, rule: RULE_NONE};
                path_reg        <= '{seg: SEG_EMPTY, depth: '0};
                byte_count_reg  <= '0;
                key_invalid_reg <= 1'b0;
            end else begin
                utf_reg         <= utf_next;
                path_reg        <= path_next;
                byte_count_reg  <= count_upd;
                key_invalid_reg <= invalid_upd;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (consume && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (consume && in_last_reg) begin
            m_status_reg <= status_next;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Backpressure only comes from a full input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg)
        else $error("s_ready low with an empty input register");

    // A second-byte rule only stands while two or more bytes are expected
    assert property (@(posedge aclk) disable iff (!aresetn)
        utf_reg.rule != RULE_NONE |-> utf_reg.cont_left >= 2'd2)
        else $error("range rule pending without a multi-byte sequence");

    // Closing a key clears its state and raises a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        consume && in_last_reg |=> m_valid && byte_count_reg == '0
            && path_reg.depth == '0 && !key_invalid_reg)
        else $error("key state not cleared or no result after the last item");

    // Status is never the unused code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK || m_status == STATUS_TOO_LONG
            || m_status == STATUS_INVALID))
        else $error("unused status code");

endmodule : object_key_validator

`default_nettype wire
